### sv/bbs_pkg.sv
// ============================================================================
// bbs_pkg - shared definitions for the block bit scrambler
// Sizes, register indexes, inversion rule codes and the transfer payloads
// used by the cell row and the top level.
// ============================================================================
`default_nettype none

package bbs_pkg;

	// Block geometry
	localparam int MAX_BLOCK = 64;
	localparam int POS_W     = $clog2(MAX_BLOCK);
	localparam int CNT_W     = $clog2(MAX_BLOCK + 1);

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd2;

	localparam logic [CFG_W-1:0] SIZE_RESET = 7'd4;

	// Method codes
	localparam logic METHOD_INVERT = 1'b0;
	localparam logic METHOD_ROTATE = 1'b1;

	// Inversion rules of the count-dependent method
	localparam logic [1:0] RULE_ALL   = 2'd0;
	localparam logic [1:0] RULE_ODD   = 2'd1;
	localparam logic [1:0] RULE_THIRD = 2'd2;

	// Transfer payloads
	typedef struct packed {
		logic in_bit;
		logic message_end;
	} in_item_t;

	typedef struct packed {
		logic out_bit;
		logic block_last;
	} out_item_t;

	// Broadcast control from the top level to every cell
	typedef struct packed {
		logic             in_bit;
		logic             gather;
		logic             load;
		logic             shift;
		logic             method;
		logic             decode;
		logic [1:0]       rule;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] last_idx;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### sv/bbs_cell.sv
// ============================================================================
// bbs_cell - one bit position of the scrambler row
// Holds one gathered input bit and one output bit. At block completion it
// forms its transformed bit from itself and its neighbors; while the block
// drains it passes its output bit down toward position zero.
// ============================================================================
`default_nettype none

module bbs_cell
	import bbs_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [POS_W-1:0] idx,
	input  wire logic [1:0]       idx_mod3,
	input  wire logic             src_prev,
	input  wire logic             src_next,
	input  wire logic             src_head,
	input  wire logic             o_next,
	output logic                  src,
	output logic                  o
);

	logic g_q;
	logic o_q;
	logic hit;
	logic is_last;
	logic inv;
	logic res;

	assign hit     = (idx == ctrl.pos);
	assign is_last = (idx == ctrl.last_idx);

	// Plain bit of this position: the arriving bit lands here this cycle
	assign src = hit ? ctrl.in_bit : g_q;

	// Select the inversion pattern of this position
	always_comb begin
		case (ctrl.rule)
			RULE_ALL:   inv = 1'b1;
			RULE_ODD:   inv = idx[0];
			RULE_THIRD: inv = (idx_mod3 == 2'd2);
			default:    inv = 1'b1;
		endcase
	end

	// Transformed bit: inversion, or rotation by one place
	always_comb begin
		if (ctrl.method == METHOD_INVERT) begin
			res = src ^ inv;
		end else if (!ctrl.decode) begin
			res = (idx == '0) ? ctrl.in_bit : src_prev;
		end else begin
			res = is_last ? src_head : src_next;
		end
	end

	// Capture the arriving bit at its position
	always_ff @(posedge clk) begin
		if (ctrl.gather && hit) begin
			g_q <= ctrl.in_bit;
		end
	end

	// Load the transformed block, or shift toward position zero
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			o_q <= res;
		end else if (ctrl.shift) begin
			o_q <= o_next;
		end
	end

	assign o = o_q;

endmodule

`default_nettype wire

### sv/block_bit_scrambler.sv
// ============================================================================
// block_bit_scrambler - serial block scrambler and descrambler
// Gathers message bits into blocks and emits each completed block bit by bit
// after inversion or rotation, with the final bit of each block marked.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one message bit per
//   transfer; message_end marks the last bit and restarts the block history
//   after that bit, dropping an unfinished block.
//   Output channel (out_valid/out_ready/out_data) delivers the block bits,
//   position zero first, block_last on the final bit.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
//   Latency: the first bit of a block is offered the cycle after the transfer
//   of the bit that completes it. Throughput: one bit per cycle on each side;
//   the row of cells holds one block being gathered and one being drained.
//   A completing bit waits while the previous block still has bits to
//   deliver, unless the last of them transfers in the same cycle, so a
//   stalled receiver backs up the sender at the next block boundary.
//   Reset: method zero, encode, block size 4, empty row,
//   next block is the first of a message; no clearing pass.
// ============================================================================
`default_nettype none

module block_bit_scrambler
	import bbs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers
	logic             method_q;
	logic             decode_q;
	logic [CFG_W-1:0] size_q;

	// Gather state and block history
	logic [POS_W-1:0] fill_q;
	logic [1:0]       mod3_q;
	logic [CNT_W-1:0] c_src_q;
	logic [CNT_W-1:0] c_odd_q;
	logic [CNT_W-1:0] c_third_q;
	logic [CNT_W-1:0] prev_ones_q;
	logic             first_q;

	// Output drain count
	logic [CNT_W-1:0] out_cnt_q;

	logic [CNT_W-1:0] n_eff;
	logic [POS_W-1:0] last_idx;
	logic             drop;
	logic [POS_W-1:0] pos;
	logic [1:0]       pos_mod3;
	logic             complete;
	logic             in_xfer;
	logic             out_xfer;
	logic             load;
	logic [1:0]       rule;
	logic [CNT_W:0]   twice;
	logic [CNT_W-1:0] src_tot;
	logic [CNT_W-1:0] odd_tot;
	logic [CNT_W-1:0] third_tot;
	logic [CNT_W-1:0] new_ones;
	cell_ctrl_t       ctrl;

	logic [MAX_BLOCK-1:0] src_v;
	logic [MAX_BLOCK-1:0] o_v;
	logic [MAX_BLOCK-1:0] src_dn;
	logic [MAX_BLOCK-1:0] src_up;
	logic [MAX_BLOCK-1:0] o_up;

	// Saturate the block size into 1..MAX_BLOCK
	always_comb begin
		if (size_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (size_q > CFG_W'(MAX_BLOCK)) begin
			n_eff = CNT_W'(MAX_BLOCK);
		end else begin
			n_eff = CNT_W'(size_q);
		end
	end

	assign last_idx = POS_W'(n_eff - CNT_W'(1));

	// Drop a block left over from a larger block size
	assign drop     = ({1'b0, fill_q} >= n_eff);
	assign pos      = drop ? '0 : fill_q;
	assign pos_mod3 = drop ? 2'd0 : mod3_q;
	assign complete = (pos == last_idx);

	// Hold the completing bit while the previous block still drains
	assign in_ready  = !complete || (out_cnt_q == '0) ||
		((out_cnt_q == CNT_W'(1)) && out_ready);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = (out_cnt_q != '0);
	assign out_xfer  = out_valid && out_ready;
	assign load      = in_xfer && complete;

	// Pick the inversion rule from the previous plain block
	assign twice = {prev_ones_q, 1'b0};
	always_comb begin
		if (method_q == METHOD_INVERT && !first_q) begin
			if (twice == {1'b0, n_eff}) begin
				rule = RULE_ALL;
			end else if (twice < {1'b0, n_eff}) begin
				rule = RULE_ODD;
			end else begin
				rule = RULE_THIRD;
			end
		end else begin
			rule = RULE_ALL;
		end
	end

	// Running ones counts of the plain bits and of each inverted pattern
	assign src_tot   = (drop ? '0 : c_src_q) + CNT_W'(in_data.in_bit);
	assign odd_tot   = (drop ? '0 : c_odd_q) + CNT_W'(in_data.in_bit ^ pos[0]);
	assign third_tot = (drop ? '0 : c_third_q) +
		CNT_W'(in_data.in_bit ^ (pos_mod3 == 2'd2));

	// Ones count of the plain block: input when encoding, output when decoding
	always_comb begin
		if (method_q == METHOD_ROTATE || !decode_q) begin
			new_ones = src_tot;
		end else begin
			case (rule)
				RULE_ALL:   new_ones = n_eff - src_tot;
				RULE_ODD:   new_ones = odd_tot;
				RULE_THIRD: new_ones = third_tot;
				default:    new_ones = n_eff - src_tot;
			endcase
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_INVERT;
			decode_q <= 1'b0;
			size_q   <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_METHOD: method_q <= cfg_data[0];
				CFG_DECODE: decode_q <= cfg_data[0];
				CFG_SIZE:   size_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Advance the gather state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			mod3_q      <= 2'd0;
			c_src_q     <= '0;
			c_odd_q     <= '0;
			c_third_q   <= '0;
			prev_ones_q <= '0;
			first_q     <= 1'b1;
		end else if (in_xfer) begin
			if (in_data.message_end) begin
				fill_q      <= '0;
				mod3_q      <= 2'd0;
				c_src_q     <= '0;
				c_odd_q     <= '0;
				c_third_q   <= '0;
				prev_ones_q <= '0;
				first_q     <= 1'b1;
			end else if (complete) begin
				fill_q      <= '0;
				mod3_q      <= 2'd0;
				c_src_q     <= '0;
				c_odd_q     <= '0;
				c_third_q   <= '0;
				prev_ones_q <= new_ones;
				first_q     <= 1'b0;
			end else begin
				fill_q    <= pos + POS_W'(1);
				mod3_q    <= (pos_mod3 == 2'd2) ? 2'd0 : pos_mod3 + 2'd1;
				c_src_q   <= src_tot;
				c_odd_q   <= odd_tot;
				c_third_q <= third_tot;
			end
		end
	end

	// Load a finished block, then count it down as bits transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (load) begin
			out_cnt_q <= n_eff;
		end else if (out_xfer) begin
			out_cnt_q <= out_cnt_q - CNT_W'(1);
		end
	end

	// Broadcast control to the cell row
	always_comb begin
		ctrl.in_bit   = in_data.in_bit;
		ctrl.gather   = in_xfer;
		ctrl.load     = load;
		ctrl.shift    = out_xfer;
		ctrl.method   = method_q;
		ctrl.decode   = decode_q;
		ctrl.rule     = rule;
		ctrl.pos      = pos;
		ctrl.last_idx = last_idx;
	end

	// Neighbor links of the row
	assign src_dn = {src_v[MAX_BLOCK-2:0], 1'b0};
	assign src_up = {1'b0, src_v[MAX_BLOCK-1:1]};
	assign o_up   = {1'b0, o_v[MAX_BLOCK-1:1]};

	for (genvar i = 0; i < MAX_BLOCK; i++) begin : g_cell
		localparam logic [1:0] IDX_MOD3 = 2'(i % 3);

		bbs_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.idx      (POS_W'(i)),
			.idx_mod3 (IDX_MOD3),
			.src_prev (src_dn[i]),
			.src_next (src_up[i]),
			.src_head (src_v[0]),
			.o_next   (o_up[i]),
			.src      (src_v[i]),
			.o        (o_v[i])
		);
	end

	assign out_data.out_bit    = o_v[0];
	assign out_data.block_last = (out_cnt_q == CNT_W'(1));

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= CNT_W'(MAX_BLOCK))
		else $error("output count beyond block capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (out_cnt_q == '0 || (out_cnt_q == CNT_W'(1) && out_ready)))
		else $error("block loaded over undelivered bits");

	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_cnt_q == $past(n_eff)))
		else $error("drain count does not match block size");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (complete || in_data.message_end)) |=> (fill_q == '0))
		else $error("gather position not restarted");
`endif

endmodule

`default_nettype wire

### dv/tb_block_bit_scrambler.sv
// ============================================================================
// tb_block_bit_scrambler - self-checking bench for the block bit scrambler
// Sends message bits through the valid/ready input channel, mirrors every
// transfer in a behavioral scrambler with its own copy of the registers and
// block history, and compares each output transfer with the oldest predicted
// bit. A short directed sequence is followed by random phases, which may
// change the register settings. Both channels idle at random or not at all.
// ============================================================================
`default_nettype none

module tb_block_bit_scrambler;
	timeunit 1ns;
	timeprecision 1ps;

	import bbs_pkg::*;

	localparam logic                 MODE_ENCODE = 1'b0;
	localparam logic                 MODE_DECODE = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
	localparam int MAX_GAP     = 11;
	localparam int RAND_BITS   = 80;
	localparam int SETTLE      = 4;
	localparam int DRAIN_LIMIT = 20000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Stimulus and expectation stores
	in_item_t  bits_to_send[$];
	out_item_t scrambled_due[$];
	in_item_t  next_item;
	bit        no_idle = 1'b0;
	int        send_gap;
	int        hold_left;
	int        hold_draw;
	int        errors = 0;
	int        bits_in = 0;
	int        bits_out = 0;
	int        blocks_out = 0;
	int        reg_writes = 0;

	// Shadow registers and block history of the scrambler
	logic                 sh_method = METHOD_INVERT;
	logic                 sh_decode = MODE_ENCODE;
	logic [CFG_W-1:0]     sh_size = SIZE_RESET;
	logic [MAX_BLOCK-1:0] gather_buf = '0;
	int                   gather_cnt = 0;
	int                   prev_ones = 0;
	bit                   first_of_msg = 1'b1;

	block_bit_scrambler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Effective block length: zero acts as one, large values saturate
	function automatic int block_len();
		if (sh_size == 0)
			return 1;
		if (sh_size > MAX_BLOCK)
			return MAX_BLOCK;
		return int'(sh_size);
	endfunction

	// Gather one message bit and queue the scrambled block once it is full
	function automatic void scramble_bit(input in_item_t it);
		int                   n;
		int                   i;
		int                   src;
		logic [1:0]           rule;
		logic                 b;
		logic [MAX_BLOCK-1:0] res;
		out_item_t            o;
		n = block_len();
		// drop a block that a lowered size has already overrun
		if (gather_cnt >= n) begin
			gather_buf = '0;
			gather_cnt = 0;
		end
		gather_buf[gather_cnt] = it.in_bit;
		gather_cnt++;
		if (gather_cnt == n) begin
			rule = RULE_ALL;
			if (sh_method == METHOD_INVERT && !first_of_msg) begin
				if (2 * prev_ones == n)
					rule = RULE_ALL;
				else if (2 * prev_ones < n)
					rule = RULE_ODD;
				else
					rule = RULE_THIRD;
			end
			res = '0;
			for (i = 0; i < n; i++) begin
				if (sh_method == METHOD_INVERT) begin
					b = gather_buf[i];
					case (rule)
						RULE_ALL: b = ~b;
						RULE_ODD: if (i % 2 == 1) b = ~b;
						default: if (i % 3 == 2) b = ~b;
					endcase
				end else begin
					if (sh_decode == MODE_ENCODE)
						src = (i == 0) ? n - 1 : i - 1;
					else
						src = (i == n - 1) ? 0 : i + 1;
					b = gather_buf[src];
				end
				res[i] = b;
				o.out_bit = b;
				o.block_last = (i == n - 1);
				scrambled_due.push_back(o);
			end
			// history follows the plain block under either method
			prev_ones = $countones(sh_decode == MODE_DECODE ? res : gather_buf);
			first_of_msg = 1'b0;
			gather_buf = '0;
			gather_cnt = 0;
		end
		if (it.message_end) begin
			gather_buf = '0;
			gather_cnt = 0;
			prev_ones = 0;
			first_of_msg = 1'b1;
		end
	endfunction

	// Input driver: random gap before each item, hold payload until transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (bits_to_send.size() > 0) begin
				next_item = bits_to_send.pop_front();
				in_valid <= 1'b1;
				in_data <= next_item;
				send_gap <= no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: random stall after each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (!out_ready) begin
			if (hold_left <= 1)
				out_ready <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (out_valid) begin
			hold_draw = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			out_ready <= (hold_draw == 0);
			hold_left <= hold_draw;
		end
	end

	// Monitor: predict on input transfers, check output transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				scramble_bit(in_data);
				bits_in++;
			end
			if (out_valid && out_ready) begin
				bits_out++;
				if (out_data.block_last)
					blocks_out++;
				if (scrambled_due.size() == 0) begin
					$display("%0t: unexpected output transfer, got bit %b last %b",
						$time, out_data.out_bit, out_data.block_last);
					errors++;
				end else begin
					if (out_data !== scrambled_due[0]) begin
						$display("%0t: output mismatch, expected bit %b last %b, got bit %b last %b",
							$time, scrambled_due[0].out_bit, scrambled_due[0].block_last,
							out_data.out_bit, out_data.block_last);
						errors++;
					end
					void'(scrambled_due.pop_front());
				end
			end
		end
	end

	task automatic push_bit(input logic b, input logic last);
		in_item_t it;
		it.in_bit = b;
		it.message_end = last;
		bits_to_send.push_back(it);
	endtask

	// Queue n bits, position zero first, optionally ending the message
	task automatic queue_bits(input logic [MAX_BLOCK-1:0] bits, input int n,
		input logic end_last);
		int k;
		for (k = 0; k < n; k++)
			push_bit(bits[k], end_last && (k == n - 1));
	endtask

	// Hold off until every bit is sent and every result has arrived
	task automatic wait_idle();
		int guard;
		guard = 0;
		while ((bits_to_send.size() != 0 || in_valid || scrambled_due.size() != 0)
			&& guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_METHOD: sh_method = val[0];
			CFG_DECODE: sh_decode = val[0];
			CFG_SIZE: sh_size = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	// Stimulus sequencer
	initial begin
		int               phase;
		int               rand_bits;
		int               n;
		int               total;
		int               k;
		int               kind;
		int               extra;
		logic             e;
		logic [CFG_W-1:0] rv;

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: inversion, encode, four-bit blocks.
		// First block inverted, then more ones, equal, more zeros; end on a boundary.
		queue_bits('b1101, 4, 1'b0);
		queue_bits('b0011, 4, 1'b0);
		queue_bits('b1000, 4, 1'b0);
		queue_bits('b0111, 4, 1'b1);
		wait_idle();

		// Rotate right over a three-bit block
		write_reg(CFG_METHOD, CFG_W'(METHOD_ROTATE));
		write_reg(CFG_SIZE, 7'd3);
		queue_bits('b001, 3, 1'b0);
		wait_idle();

		// Size zero acts as one bit: passes unchanged under rotation
		write_reg(CFG_DECODE, CFG_W'(MODE_DECODE));
		write_reg(CFG_SIZE, 7'd0);
		queue_bits('b1, 1, 1'b1);
		wait_idle();

		// Leave a partial block, lower the size, then drop a partial at message end
		write_reg(CFG_METHOD, CFG_W'(METHOD_INVERT));
		write_reg(CFG_SIZE, 7'd5);
		queue_bits('b111, 3, 1'b0);
		wait_idle();
		write_reg(CFG_SIZE, 7'd2);
		queue_bits('b110, 3, 1'b1);
		wait_idle();

		// Random phases: mostly whole messages, some open or broken ones
		phase = 0;
		rand_bits = 0;
		while (rand_bits < RAND_BITS) begin
			wait_idle();
			no_idle = ($urandom_range(0, 3) == 0);
			if (phase == 0 || $urandom_range(0, 1)) begin
				rv = CFG_W'($urandom_range(0, 127));
				write_reg(CFG_METHOD, rv);
			end
			if (phase == 0 || $urandom_range(0, 1)) begin
				rv = CFG_W'($urandom_range(0, 127));
				write_reg(CFG_DECODE, rv);
			end
			if ($urandom_range(0, 7) == 0) begin
				rv = CFG_W'($urandom_range(0, 127));
				write_reg(CFG_SPARE, rv);
			end
			if (phase == 1) begin
				// one full-width block, reached by saturation
				write_reg(CFG_SIZE, 7'd64);
				write_reg(CFG_SIZE, 7'd127);
			end else if (phase == 0 || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: rv = 7'd0;
					1: rv = 7'd1;
					default: rv = CFG_W'($urandom_range(2, 8));
				endcase
				write_reg(CFG_SIZE, rv);
			end
			n = block_len();
			total = (n == MAX_BLOCK) ? n : n * $urandom_range(1, 4);
			kind = $urandom_range(0, 7);
			for (k = 0; k < total; k++) begin
				e = (k == total - 1) && (kind < 5);
				if (kind == 7 && $urandom_range(0, 9) == 0)
					e = 1'b1;
				push_bit(1'($urandom_range(0, 1)), e);
			end
			// leave an unfinished block behind for the next phase
			extra = 0;
			if (kind == 5 || kind == 6) begin
				extra = $urandom_range(0, n - 1);
				for (k = 0; k < extra; k++)
					push_bit(1'($urandom_range(0, 1)), 1'b0);
			end
			rand_bits += total + extra;
			phase++;
		end

		wait_idle();
		no_idle = 1'b0;
		repeat (2 * SETTLE) @(posedge clk);
		if (scrambled_due.size() != 0) begin
			$display("%0t: %0d expected output bits never arrived",
				$time, scrambled_due.size());
			errors++;
		end
		$display("Sent %0d message bits (%0d random, %0d phases), %0d register writes",
			bits_in, rand_bits, phase, reg_writes);
		$display("Checked %0d scrambled bits in %0d blocks, %0d errors",
			bits_out, blocks_out, errors);
		if (errors == 0)
			$display("PASS block_bit_scrambler");
		else
			$display("FAIL block_bit_scrambler");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timeout with %0d bits unsent and %0d results outstanding",
			bits_to_send.size(), scrambled_due.size());
		$display("FAIL block_bit_scrambler");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
sv/bbs_pkg.sv
sv/bbs_cell.sv
sv/block_bit_scrambler.sv
dv/tb_block_bit_scrambler.sv
